FILE: rtl/bcd_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT block decoder.
// No dependencies; imported by bcd_palette and bc_texture_block_decoder.
`default_nettype none

package bcd_pkg;

	// Block formats. The unused fourth code decodes as DXT1.
	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2
	} fmt_t;

	localparam logic [3:0] LAST_TEXEL     = 4'hF;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR    = 8'h00;
	localparam logic [1:0] CI_TRANSPARENT = 2'd3;

	// Reciprocals for exact truncating division over the value ranges used here.
	localparam logic [13:0] RECIP31 = 14'd8457;   // x < 8192,   shift 18
	localparam logic [14:0] RECIP63 = 15'd16645;  // x < 16384,  shift 20
	localparam logic [9:0]  RECIP3  = 10'd683;    // x < 1024,   shift 11
	localparam logic [11:0] RECIP7  = 12'd2341;   // x < 2048,   shift 14
	localparam logic [11:0] RECIP5  = 12'd3277;   // x < 2048,   shift 14

	// Endpoints after expansion, alpha numerators, and the raw index words.
	typedef struct packed {
		fmt_t             fmt;
		logic             three_color;
		logic [7:0]       r0;
		logic [7:0]       g0;
		logic [7:0]       b0;
		logic [7:0]       r1;
		logic [7:0]       g1;
		logic [7:0]       b1;
		logic             a_gt;
		logic [7:0]       a0;
		logic [7:0]       a1;
		logic [5:0][10:0] anum;
		logic [63:0]      alpha_block;
		logic [31:0]      cidx;
	} bcd_ends_t;

	// Full color palette and alpha table for one block.
	typedef struct packed {
		fmt_t            fmt;
		logic            three_color;
		logic [3:0][7:0] red;
		logic [3:0][7:0] green;
		logic [3:0][7:0] blue;
		logic [7:0][7:0] atab;
		logic [63:0]     alpha_block;
		logic [31:0]     cidx;
	} bcd_pal_t;

	// v * 255 / 31, truncated.
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [12:0] x;
		logic [26:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = {14'd0, x} * {13'd0, RECIP31};
		return p[25:18];
	endfunction

	// v * 255 / 63, truncated.
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [13:0] x;
		logic [28:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = {15'd0, x} * {14'd0, RECIP63};
		return p[27:20];
	endfunction

	// (2a + b) / 3, truncated.
	function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
		logic [9:0]  x;
		logic [19:0] p;
		x = {1'b0, a, 1'b0} + {2'b00, b};
		p = {10'd0, x} * {10'd0, RECIP3};
		return p[18:11];
	endfunction

	// (a + b) / 2, truncated.
	function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * {11'd0, RECIP7};
		return p[21:14];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * {11'd0, RECIP5};
		return p[21:14];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bcd_if.sv
// Valid/ready channel interfaces for compressed blocks and decoded texels.
// No dependencies.
`default_nettype none

interface bcd_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] alpha_block;
	logic [63:0] color_block;

	modport source(output valid, output alpha_block, output color_block, input ready);
	modport sink(input valid, input alpha_block, input color_block, output ready);
endinterface

interface bcd_texel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [3:0] texel_index;
	logic       last_texel;

	modport source(output valid, output red, output green, output blue, output alpha,
		output texel_index, output last_texel, input ready);
	modport sink(input valid, input red, input green, input blue, input alpha,
		input texel_index, input last_texel, output ready);
endinterface

`default_nettype wire

FILE: rtl/bc_texture_block_decoder.sv
// Top level of the DXT1/DXT3/DXT5 block decoder: block register, endpoint
// stage, palette stage and texel output register. Depends on bcd_pkg, bcd_if, bcd_palette.
//
//   Channel  | Direction | Payload                                        | Unit
//   blocks   | in        | alpha_block, color_block                       | one 4x4 block
//   texels   | out       | red, green, blue, alpha, texel_index, last_texel | one texel
//   cfg      | in        | cfg_wdata (block_format)                       | register write
//
// Each block yields 16 texels, one per cycle from the texel output register while
// the output is not stalled; a block passes through the block, endpoint and palette
// registers before its first texel reaches the texel output register.
// Up to two further blocks wait in the block and endpoint stages while a block is sent.
// Reset clears the format register to DXT1 and empties every stage.
// A stalled texel output holds its item and backs up the stages behind it.
`default_nettype none

module bc_texture_block_decoder
	import bcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	bcd_block_if.sink        blocks,
	bcd_texel_if.source      texels
);

	logic [1:0]  block_format_q;
	fmt_t        fmt_cur;

	logic        s1_valid_q;
	fmt_t        fmt_s1;
	logic [63:0] alpha_s1;
	logic [63:0] color_s1;

	logic        s2_valid_q;
	bcd_ends_t   ends_d;
	bcd_ends_t   ends_s2;

	logic        s3_valid_q;
	bcd_pal_t    pal_d;
	bcd_pal_t    pal_s3;
	logic [3:0]  cnt_q;

	logic        tv_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  alpha_q;
	logic [3:0]  index_q;
	logic        last_q;

	logic        s1_load;
	logic        s2_load;
	logic        s3_load;
	logic        s3_done;
	logic        out_load;

	logic [1:0]  ci;
	logic [3:0]  a_nib;
	logic [5:0]  a_pos;
	logic [2:0]  a_sel;
	logic [7:0]  alpha_d;

	// Format register; the unused code decodes as DXT1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_format_q <= FMT_DXT1;
		end else if (cfg_we) begin
			block_format_q <= cfg_wdata;
		end
	end

	always_comb begin
		case (block_format_q)
			FMT_DXT3: fmt_cur = FMT_DXT3;
			FMT_DXT5: fmt_cur = FMT_DXT5;
			default:  fmt_cur = FMT_DXT1;
		endcase
	end

	// Stage handshake: each stage moves on when the one after it frees up.
	assign out_load     = s3_valid_q && (!tv_q || texels.ready);
	assign s3_done      = out_load && (cnt_q == LAST_TEXEL);
	assign s3_load      = s2_valid_q && (!s3_valid_q || s3_done);
	assign s2_load      = s1_valid_q && (!s2_valid_q || s3_load);
	assign blocks.ready = !s1_valid_q || s2_load;
	assign s1_load      = blocks.valid && blocks.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			cnt_q      <= '0;
			tv_q       <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (s3_load) begin
				s2_valid_q <= 1'b0;
			end
			if (s3_load) begin
				s3_valid_q <= 1'b1;
			end else if (s3_done) begin
				s3_valid_q <= 1'b0;
			end
			if (out_load) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (out_load) begin
				tv_q <= 1'b1;
			end else if (texels.ready) begin
				tv_q <= 1'b0;
			end
		end
	end

	// Endpoint stage: expand RGB565 endpoints and form the alpha numerators.
	always_comb begin
		ends_d.fmt         = fmt_s1;
		ends_d.three_color = (fmt_s1 == FMT_DXT1) && (color_s1[15:0] <= color_s1[31:16]);
		ends_d.r0          = expand5(color_s1[15:11]);
		ends_d.g0          = expand6(color_s1[10:5]);
		ends_d.b0          = expand5(color_s1[4:0]);
		ends_d.r1          = expand5(color_s1[31:27]);
		ends_d.g1          = expand6(color_s1[26:21]);
		ends_d.b1          = expand5(color_s1[20:16]);
		ends_d.a0          = alpha_s1[7:0];
		ends_d.a1          = alpha_s1[15:8];
		ends_d.a_gt        = alpha_s1[7:0] > alpha_s1[15:8];
		ends_d.alpha_block = alpha_s1;
		ends_d.cidx        = color_s1[63:32];
		for (int i = 1; i < 7; i++) begin
			if (ends_d.a_gt) begin
				ends_d.anum[i - 1] = 11'(7 - i) * {3'd0, alpha_s1[7:0]}
					+ 11'(i) * {3'd0, alpha_s1[15:8]};
			end else if (i < 5) begin
				ends_d.anum[i - 1] = 11'(5 - i) * {3'd0, alpha_s1[7:0]}
					+ 11'(i) * {3'd0, alpha_s1[15:8]};
			end else begin
				ends_d.anum[i - 1] = 11'd0;
			end
		end
	end

	// Palette stage.
	bcd_palette u_palette (
		.ends (ends_s2),
		.pal  (pal_d)
	);

	// Per-texel selection of color and alpha.
	always_comb begin
		ci    = pal_s3.cidx[{cnt_q, 1'b0} +: 2];
		a_nib = pal_s3.alpha_block[{cnt_q, 2'b00} +: 4];
		a_pos = 6'd16 + {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0};
		a_sel = pal_s3.alpha_block[a_pos +: 3];
		case (pal_s3.fmt)
			FMT_DXT3: alpha_d = {a_nib, a_nib};
			FMT_DXT5: alpha_d = pal_s3.atab[a_sel];
			default:  alpha_d = (pal_s3.three_color && (ci == CI_TRANSPARENT)) ?
				ALPHA_CLEAR : ALPHA_OPAQUE;
		endcase
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			fmt_s1   <= fmt_cur;
			alpha_s1 <= blocks.alpha_block;
			color_s1 <= blocks.color_block;
		end
		if (s2_load) begin
			ends_s2 <= ends_d;
		end
		if (s3_load) begin
			pal_s3 <= pal_d;
		end
		if (out_load) begin
			red_q   <= pal_s3.red[ci];
			green_q <= pal_s3.green[ci];
			blue_q  <= pal_s3.blue[ci];
			alpha_q <= alpha_d;
			index_q <= cnt_q;
			last_q  <= (cnt_q == LAST_TEXEL);
		end
	end

	assign texels.valid       = tv_q;
	assign texels.red         = red_q;
	assign texels.green       = green_q;
	assign texels.blue        = blue_q;
	assign texels.alpha       = alpha_q;
	assign texels.texel_index = index_q;
	assign texels.last_texel  = last_q;

	// The texel counter only moves while a block sits in the palette stage.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s3_valid_q |-> (cnt_q == 4'd0))
		else $error("texel counter off zero with no block in the palette stage");

	// A texel sent from count fifteen carries the last-texel mark, and only it.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (texels.last_texel == ($past(cnt_q) == LAST_TEXEL)))
		else $error("last-texel mark does not match the texel count");

	// A block in the endpoint stage is never dropped before it moves on.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !s3_load) |=> s2_valid_q)
		else $error("endpoint stage lost a block");

endmodule

`default_nettype wire

FILE: rtl/bcd_palette.sv
// Builds the four-entry color palette and eight-entry alpha table of a block
// from its expanded endpoints. Depends on bcd_pkg.
`default_nettype none

module bcd_palette
	import bcd_pkg::*;
(
	input  bcd_ends_t ends,
	output bcd_pal_t  pal
);

	// Color palette: thirds in four-color mode, half and black in three-color mode.
	always_comb begin
		pal.fmt         = ends.fmt;
		pal.three_color = ends.three_color;
		pal.alpha_block = ends.alpha_block;
		pal.cidx        = ends.cidx;
		pal.red[0]      = ends.r0;
		pal.green[0]    = ends.g0;
		pal.blue[0]     = ends.b0;
		pal.red[1]      = ends.r1;
		pal.green[1]    = ends.g1;
		pal.blue[1]     = ends.b1;
		if (ends.three_color) begin
			pal.red[2]   = half(ends.r0, ends.r1);
			pal.green[2] = half(ends.g0, ends.g1);
			pal.blue[2]  = half(ends.b0, ends.b1);
			pal.red[3]   = 8'd0;
			pal.green[3] = 8'd0;
			pal.blue[3]  = 8'd0;
		end else begin
			pal.red[2]   = third(ends.r0, ends.r1);
			pal.green[2] = third(ends.g0, ends.g1);
			pal.blue[2]  = third(ends.b0, ends.b1);
			pal.red[3]   = third(ends.r1, ends.r0);
			pal.green[3] = third(ends.g1, ends.g0);
			pal.blue[3]  = third(ends.b1, ends.b0);
		end

		// Alpha table: six sevenths, or four fifths followed by fully clear and opaque.
		pal.atab[0] = ends.a0;
		pal.atab[1] = ends.a1;
		for (int i = 1; i < 7; i++) begin
			if (ends.a_gt) begin
				pal.atab[i + 1] = div7(ends.anum[i - 1]);
			end else if (i < 5) begin
				pal.atab[i + 1] = div5(ends.anum[i - 1]);
			end else if (i == 5) begin
				pal.atab[i + 1] = ALPHA_CLEAR;
			end else begin
				pal.atab[i + 1] = ALPHA_OPAQUE;
			end
		end
	end

endmodule

`default_nettype wire
